// ===== sv/rtq_pkg.sv =====
package rtq_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_POLL = 2'd2;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_ACKED     = 3'd3;
  localparam logic [2:0] ST_UNMATCHED = 3'd4;
  localparam logic [2:0] ST_SENT      = 3'd5;
  localparam logic [2:0] ST_IDLE      = 3'd6;
  localparam logic [2:0] ST_DROPPED   = 3'd7;

  localparam logic [1:0] CFG_SPACING     = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

  localparam logic [15:0] SPACING_RST     = 16'd1000;
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;
  localparam logic [11:0] MAX_LENGTH_RST  = 12'd512;

  localparam logic [3:0] FULL_COUNT_OUT = 4'(QUEUE_DEPTH % 16);

  typedef struct packed {
    logic        sent;
    logic [3:0]  retries;
    logic [63:0] last_tx;
    logic [31:0] seq;
    logic [7:0]  handle;
  } entry_t;

  typedef struct packed {
    logic       latch_in;
    logic       enq_write;
    logic       rd_head;
    logic       advance;
    logic       shift_write;
    logic       poll_write;
    logic       poll_retry;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_set;
    logic [2:0] res_status;
    logic       res_tx;
    logic       res_retry;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       too_long;
    logic       full;
    logic       empty;
    logic       last;
    logic       match;
    logic       sent;
    logic       waiting;
    logic       exhausted;
    logic       out_free;
  } sts_t;

endpackage

// ===== sv/retransmit_queue_with_ack.sv =====
// Sender-side retransmission queue holding up to rtq_pkg::QUEUE_DEPTH outstanding frames in
// order. Each input transaction is an enqueue, an acknowledgement or a poll of the head frame,
// and yields exactly one result transaction. Entries live in a small entry memory that is
// walked one entry per cycle. An enqueue, an unused function code, or an acknowledgement or
// poll on an empty queue is settled at decode; a poll of a non-empty queue reads the head and
// then sends or waits. An acknowledgement searches until it matches and then closes the gap,
// as does a drop of the head. If the previous result has not yet been taken, a transaction
// waits in its done state until it is. A new transaction is accepted while the previous result
// still waits in the output register. Configuration writes must be issued only while the block
// is idle.
module retransmit_queue_with_ack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] seq_i,
  input  logic [7:0]  frame_handle_i,
  input  logic [11:0] frame_length_i,
  input  logic [63:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        tx_valid_o,
  output logic [31:0] tx_seq_o,
  output logic [7:0]  tx_handle_o,
  output logic        tx_is_retry_o,
  output logic [3:0]  queued_count_o
);

  rtq_pkg::cmd_t cmd;
  rtq_pkg::sts_t sts;

  rtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .seq_i          (seq_i),
    .frame_handle_i (frame_handle_i),
    .frame_length_i (frame_length_i),
    .now_ms_i       (now_ms_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .tx_valid_o     (tx_valid_o),
    .tx_seq_o       (tx_seq_o),
    .tx_handle_o    (tx_handle_o),
    .tx_is_retry_o  (tx_is_retry_o),
    .queued_count_o (queued_count_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ===== sv/rtq_ctrl.sv =====
module rtq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rtq_pkg::sts_t   sts_i,
  output rtq_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_POLL   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.func)
          rtq_pkg::FUNC_ENQ: begin
            cmd_o.res_set = 1'b1;
            state_d       = S_DONE;
            if (sts_i.too_long) begin
              cmd_o.res_status = rtq_pkg::ST_TOO_LONG;
            end else if (sts_i.full) begin
              cmd_o.res_status = rtq_pkg::ST_FULL;
            end else begin
              cmd_o.enq_write  = 1'b1;
              cmd_o.cnt_inc    = 1'b1;
              cmd_o.res_status = rtq_pkg::ST_QUEUED;
            end
          end
          rtq_pkg::FUNC_ACK: begin
            if (sts_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = rtq_pkg::ST_UNMATCHED;
              state_d          = S_DONE;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = S_SEARCH;
            end
          end
          rtq_pkg::FUNC_POLL: begin
            if (sts_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = rtq_pkg::ST_IDLE;
              state_d          = S_DONE;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = S_POLL;
            end
          end
          default: begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = rtq_pkg::ST_IDLE;
            state_d          = S_DONE;
          end
        endcase
      end
      S_SEARCH: begin
        if (sts_i.match) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = rtq_pkg::ST_ACKED;
          if (sts_i.last) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_DONE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_SHIFT;
          end
        end else if (sts_i.last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = rtq_pkg::ST_UNMATCHED;
          state_d          = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_write = 1'b1;
        if (sts_i.last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_POLL: begin
        cmd_o.res_set = 1'b1;
        if (!sts_i.sent) begin
          cmd_o.poll_write = 1'b1;
          cmd_o.res_status = rtq_pkg::ST_SENT;
          cmd_o.res_tx     = 1'b1;
          state_d          = S_DONE;
        end else if (sts_i.waiting) begin
          cmd_o.res_status = rtq_pkg::ST_IDLE;
          state_d          = S_DONE;
        end else if (sts_i.exhausted) begin
          cmd_o.res_status = rtq_pkg::ST_DROPPED;
          if (sts_i.last) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_DONE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_SHIFT;
          end
        end else begin
          cmd_o.poll_write = 1'b1;
          cmd_o.poll_retry = 1'b1;
          cmd_o.res_status = rtq_pkg::ST_SENT;
          cmd_o.res_tx     = 1'b1;
          cmd_o.res_retry  = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/rtq_dp.sv =====
module rtq_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic [1:0]           func_i,
  input  logic [31:0]          seq_i,
  input  logic [7:0]           frame_handle_i,
  input  logic [11:0]          frame_length_i,
  input  logic [63:0]          now_ms_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [2:0]           status_o,
  output logic                 tx_valid_o,
  output logic [31:0]          tx_seq_o,
  output logic [7:0]           tx_handle_o,
  output logic                 tx_is_retry_o,
  output logic [3:0]           queued_count_o,
  input  rtq_pkg::cmd_t        cmd_i,
  output rtq_pkg::sts_t        sts_o
);

  localparam int unsigned IDX_W = rtq_pkg::IDX_W;
  localparam int unsigned CNT_W = rtq_pkg::CNT_W;

  rtq_pkg::entry_t mem_q [rtq_pkg::QUEUE_DEPTH];
  rtq_pkg::entry_t rd_q;
  rtq_pkg::entry_t poll_entry;

  logic [1:0]  func_q;
  logic [31:0] seq_q;
  logic [7:0]  handle_q;
  logic [11:0] len_q;
  logic [63:0] now_q;

  logic [15:0] spacing_q;
  logic [3:0]  max_retries_q;
  logic [11:0] max_len_q;

  logic [CNT_W-1:0] count_q, pos_q;
  logic [CNT_W-1:0] pos_p1, pos_m1;
  logic [CNT_W:0]   pos_next_ext;
  logic [CNT_W+3:0] count_ext;
  logic [63:0]      elapsed;

  logic [2:0]  res_status_q;
  logic        res_tx_q, res_retry_q;
  logic [31:0] res_seq_q;
  logic [7:0]  res_handle_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic        out_tx_q, out_retry_q;
  logic [31:0] out_seq_q;
  logic [7:0]  out_handle_q;
  logic [3:0]  out_count_q;

  assign pos_p1       = pos_q + 1'b1;
  assign pos_m1       = pos_q - 1'b1;
  assign pos_next_ext = {1'b0, pos_q} + 1'b1;
  assign count_ext    = {4'b0000, count_q};
  assign elapsed      = now_q - rd_q.last_tx;

  always_comb begin
    poll_entry         = rd_q;
    poll_entry.sent    = 1'b1;
    poll_entry.last_tx = now_q;
    if (cmd_i.poll_retry) begin
      poll_entry.retries = rd_q.retries + 4'd1;
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.too_long  = (len_q > max_len_q);
  assign sts_o.full      = (count_q >= CNT_W'(rtq_pkg::QUEUE_DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.last      = (pos_next_ext >= {1'b0, count_q});
  assign sts_o.match     = (rd_q.seq == seq_q);
  assign sts_o.sent      = rd_q.sent;
  assign sts_o.waiting   = (elapsed < {48'd0, spacing_q});
  assign sts_o.exhausted = (rd_q.retries >= max_retries_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_write) begin
      mem_q[count_q[IDX_W-1:0]] <= '{sent: 1'b0, retries: 4'd0, last_tx: 64'd0,
                                    seq: seq_q, handle: handle_q};
    end else if (cmd_i.shift_write) begin
      mem_q[pos_m1[IDX_W-1:0]] <= rd_q;
    end else if (cmd_i.poll_write) begin
      mem_q[IDX_W'(0)] <= poll_entry;
    end
    if (cmd_i.rd_head) begin
      rd_q <= mem_q[IDX_W'(0)];
    end else if (cmd_i.advance) begin
      rd_q <= mem_q[pos_p1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q   <= func_i;
      seq_q    <= seq_i;
      handle_q <= frame_handle_i;
      len_q    <= frame_length_i;
      now_q    <= now_ms_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_tx_q     <= cmd_i.res_tx;
      res_retry_q  <= cmd_i.res_retry;
      res_seq_q    <= cmd_i.res_tx ? rd_q.seq : 32'd0;
      res_handle_q <= cmd_i.res_tx ? rd_q.handle : 8'd0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_tx_q     <= res_tx_q;
      out_retry_q  <= res_retry_q;
      out_seq_q    <= res_seq_q;
      out_handle_q <= res_handle_q;
      out_count_q  <= count_ext[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q     <= rtq_pkg::SPACING_RST;
      max_retries_q <= rtq_pkg::MAX_RETRIES_RST;
      max_len_q     <= rtq_pkg::MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtq_pkg::CFG_SPACING:     spacing_q     <= cfg_wdata_i;
        rtq_pkg::CFG_MAX_RETRIES: max_retries_q <= cfg_wdata_i[3:0];
        rtq_pkg::CFG_MAX_LENGTH:  max_len_q     <= cfg_wdata_i[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.rd_head) begin
        pos_q <= '0;
      end else if (cmd_i.advance) begin
        pos_q <= pos_p1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign tx_valid_o     = out_tx_q;
  assign tx_seq_o       = out_seq_q;
  assign tx_handle_o    = out_handle_q;
  assign tx_is_retry_o  = out_retry_q;
  assign queued_count_o = out_count_q;

endmodule

// ===== sv/rtq_chk.sv =====
module rtq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [15:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  func_i,
  input logic [31:0] seq_i,
  input logic [7:0]  frame_handle_i,
  input logic [11:0] frame_length_i,
  input logic [63:0] now_ms_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        tx_valid_o,
  input logic [31:0] tx_seq_o,
  input logic [7:0]  tx_handle_o,
  input logic        tx_is_retry_o,
  input logic [3:0]  queued_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(tx_seq_o))
    else $error("result changed while stalled");

  a_tx_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_valid_o |-> status_o == rtq_pkg::ST_SENT)
    else $error("transmission without sent status");

  a_no_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_seq_o == 32'd0 && tx_handle_o == 8'd0 && !tx_is_retry_o)
    else $error("transmit fields not cleared");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rtq_pkg::ST_FULL |-> queued_count_o == rtq_pkg::FULL_COUNT_OUT)
    else $error("full reported with queue not full");

endmodule

bind retransmit_queue_with_ack rtq_chk u_rtq_chk (.*);
